FILE: hw/rtl/tccb_pkg.sv
// Shared types, codes and constants for the text console cell buffer.
package tccb_pkg;

    localparam int DEF_COLS = 100;
    localparam int DEF_ROWS = 75;

    localparam int POS_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int RGB_W   = 24;
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 80;

    // Operation codes carried in the slave-side tuser.
    localparam logic [1:0] FN_PUT   = 2'd0;
    localparam logic [1:0] FN_SET   = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_FIRST = 8'd32;
    localparam logic [7:0] CH_LAST  = 8'd126;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] BLANK_ATTR = 8'h07;
    localparam logic [7:0] ATTR_RESET = 8'h0F;
    localparam int         TAB_STOP   = 8;

    typedef struct packed {
        logic load;
        logic decode;
        logic addr;
        logic write;
        logic fill;
        logic read;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic put_wr;
        logic read_ok;
        logic row_ok;
        logic fill_last;
    } t_dp_sts;

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0000AA;
            4'd2:    rgb = 24'h00AA00;
            4'd3:    rgb = 24'h00AAAA;
            4'd4:    rgb = 24'hAA0000;
            4'd5:    rgb = 24'hAA00AA;
            4'd6:    rgb = 24'hAA5500;
            4'd7:    rgb = 24'hAAAAAA;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h5555FF;
            4'd10:   rgb = 24'h55FF55;
            4'd11:   rgb = 24'h55FFFF;
            4'd12:   rgb = 24'hFF5555;
            4'd13:   rgb = 24'hFF55FF;
            4'd14:   rgb = 24'hFFFF55;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

FILE: hw/rtl/tccb_ctrl.sv
// Sequencing state machine of the text console cell buffer.
module tccb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    input  tccb_pkg::t_dp_sts i_sts,
    output tccb_pkg::t_dp_cmd o_cmd
);
    import tccb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ADDR   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                if (i_sts.put_wr) begin
                    n_state = i_sts.row_ok ? S_WRITE : S_FILL;
                end else if (i_sts.read_ok && i_sts.row_ok) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_DONE;
            end
            S_FILL: begin
                // A row untouched since the last clear or scroll is blanked as the cell lands.
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/tccb_datapath.sv
// Cell memory, cursor, row mapping and result register of the text console cell buffer.
module tccb_datapath #(
    parameter int COLS = tccb_pkg::DEF_COLS,
    parameter int ROWS = tccb_pkg::DEF_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tccb_pkg::t_dp_cmd                i_cmd,
    output tccb_pkg::t_dp_sts                o_sts,
    input  logic [tccb_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [tccb_pkg::S_USER_W-1:0]   i_s_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [7:0]                      i_cfg_wdata,
    output logic [tccb_pkg::M_DATA_W-1:0]   o_m_axis_tdata
);
    import tccb_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    // Captured item.
    logic [1:0]        r_func;
    logic [7:0]        r_code;
    logic [POS_W-1:0]  r_in_col;
    logic [POS_W-1:0]  r_in_row;

    // Architectural state.
    logic [7:0]        r_attr;
    logic [POS_W-1:0]  r_cur_col;
    logic [POS_W-1:0]  r_cur_row;
    logic [RW-1:0]     r_top;
    logic [ROWS-1:0]   r_row_valid;

    // Decoded item.
    logic [POS_W-1:0]  r_ncol;
    logic              r_inc;
    logic              r_wr;
    logic [POS_W-1:0]  r_wcol;
    logic [7:0]        r_wchar;
    logic [RW-1:0]     r_phys;
    logic [POS_W-1:0]  r_tcol;
    logic              r_bad;

    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_base;
    logic              r_row_ok;
    logic [CW-1:0]     r_fill_cnt;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rd;

    // Result register.
    logic [CHAR_W-1:0] r_o_char;
    logic [RGB_W-1:0]  r_o_fg;
    logic [RGB_W-1:0]  r_o_bg;
    logic              r_o_shown;
    logic [POS_W-1:0]  r_o_col;
    logic [POS_W-1:0]  r_o_row;
    logic              r_o_scr;
    logic              r_o_bad;

    // Decode logic.
    logic [7:0]        d_col_p1;
    logic [7:0]        d_tab;
    logic [POS_W-1:0]  d_ncol;
    logic              d_inc;
    logic              d_wr;
    logic [POS_W-1:0]  d_wcol;
    logic [7:0]        d_wchar;
    logic [POS_W-1:0]  d_trow;
    logic [POS_W-1:0]  d_tcol;
    logic [7:0]        d_sum;
    logic [7:0]        d_phys;
    logic              d_bad;

    always_comb begin
        d_col_p1 = {1'b0, r_cur_col} + 8'd1;
        d_tab    = ({1'b0, r_cur_col} + 8'(TAB_STOP)) & ~8'(TAB_STOP - 1);
        d_ncol   = r_cur_col;
        d_inc    = 1'b0;
        d_wr     = 1'b0;
        d_wcol   = r_cur_col;
        d_wchar  = r_code;
        if (r_func == FN_PUT) begin
            if (r_code == CH_LF) begin
                d_ncol = '0;
                d_inc  = 1'b1;
            end else if (r_code == CH_CR) begin
                d_ncol = '0;
            end else if (r_code == CH_TAB) begin
                if (d_tab >= 8'(COLS)) begin
                    d_ncol = '0;
                    d_inc  = 1'b1;
                end else begin
                    d_ncol = d_tab[POS_W-1:0];
                end
            end else if (r_code == CH_BS) begin
                if (r_cur_col != '0) begin
                    d_ncol  = r_cur_col - 7'd1;
                    d_wcol  = r_cur_col - 7'd1;
                    d_wchar = BLANK_CHAR;
                    d_wr    = 1'b1;
                end
            end else if (r_code >= CH_FIRST && r_code <= CH_LAST) begin
                d_wr = 1'b1;
                if (d_col_p1 >= 8'(COLS)) begin
                    d_ncol = '0;
                    d_inc  = 1'b1;
                end else begin
                    d_ncol = d_col_p1[POS_W-1:0];
                end
            end
        end
        if (r_func == FN_READ) begin
            d_trow = r_in_row;
            d_tcol = r_in_col;
        end else begin
            d_trow = r_cur_row;
            d_tcol = d_wcol;
        end
        d_bad = ({1'b0, r_in_col} >= 8'(COLS)) || ({1'b0, r_in_row} >= 8'(ROWS));
        // Screen rows sit in a ring of memory rows starting at r_top.
        d_sum  = {1'b0, d_trow} + 8'(r_top);
        d_phys = (d_sum >= 8'(ROWS)) ? d_sum - 8'(ROWS) : d_sum;
    end

    assign o_sts.put_wr    = (r_func == FN_PUT) && r_wr;
    assign o_sts.read_ok   = (r_func == FN_READ) && !r_bad;
    assign o_sts.row_ok    = r_row_valid[r_phys];
    assign o_sts.fill_last = (r_fill_cnt == CW'(COLS - 1));

    // Finishing logic: cursor update, scroll and result.
    logic [7:0]        f_row_t;
    logic [POS_W-1:0]  f_col;
    logic [POS_W-1:0]  f_row;
    logic              f_scroll;
    logic [7:0]        f_char;
    logic [7:0]        f_at;
    logic              f_rd;

    always_comb begin
        f_row_t  = {1'b0, r_cur_row} + {7'd0, r_inc};
        f_col    = r_cur_col;
        f_row    = r_cur_row;
        f_scroll = 1'b0;
        unique case (r_func)
            FN_PUT: begin
                f_col = r_ncol;
                if (f_row_t >= 8'(ROWS)) begin
                    f_row    = POS_W'(ROWS - 1);
                    f_scroll = 1'b1;
                end else begin
                    f_row = f_row_t[POS_W-1:0];
                end
            end
            FN_SET: begin
                if ({1'b0, r_in_col} < 8'(COLS)) begin
                    f_col = r_in_col;
                end
                if ({1'b0, r_in_row} < 8'(ROWS)) begin
                    f_row = r_in_row;
                end
            end
            FN_CLEAR: begin
                f_col = '0;
                f_row = '0;
            end
            default: begin
            end
        endcase
        f_rd   = (r_func == FN_READ) && !r_bad;
        f_char = r_row_ok ? r_rd[7:0]  : BLANK_CHAR;
        f_at   = r_row_ok ? r_rd[15:8] : BLANK_ATTR;
    end

    // Memory write port.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    always_comb begin
        mem_we    = i_cmd.write || i_cmd.fill;
        mem_waddr = r_addr;
        mem_wdata = {r_attr, r_wchar};
        if (i_cmd.fill) begin
            mem_waddr = r_base + AW'(r_fill_cnt);
            if (r_fill_cnt != CW'(r_wcol)) begin
                mem_wdata = {BLANK_ATTR, BLANK_CHAR};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_s_axis_tuser;
            r_code   <= i_s_axis_tdata[7:0];
            r_in_col <= i_s_axis_tdata[14:8];
            r_in_row <= i_s_axis_tdata[21:15];
        end
        if (i_cmd.decode) begin
            r_ncol  <= d_ncol;
            r_inc   <= d_inc;
            r_wr    <= d_wr;
            r_wcol  <= d_wcol;
            r_wchar <= d_wchar;
            r_phys  <= d_phys[RW-1:0];
            r_tcol  <= d_tcol;
            r_bad   <= d_bad;
        end
        if (i_cmd.addr) begin
            r_base     <= AW'(r_phys) * AW'(COLS);
            r_addr     <= AW'(r_phys) * AW'(COLS) + AW'(r_tcol);
            r_row_ok   <= r_row_valid[r_phys];
            r_fill_cnt <= '0;
        end
        if (i_cmd.fill) begin
            r_fill_cnt <= r_fill_cnt + CW'(1);
        end
        if (i_cmd.finish) begin
            r_o_char  <= f_rd ? f_char : 8'd0;
            r_o_fg    <= f_rd ? palette_rgb(f_at[3:0]) : 24'd0;
            r_o_bg    <= f_rd ? palette_rgb(f_at[7:4]) : 24'd0;
            r_o_shown <= f_rd && (f_char != 8'd0) && (f_char != BLANK_CHAR);
            r_o_col   <= f_col;
            r_o_row   <= f_row;
            r_o_scr   <= f_scroll;
            r_o_bad   <= (r_func == FN_READ) && r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= ATTR_RESET;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_top       <= '0;
            r_row_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (i_cmd.fill && o_sts.fill_last) begin
                r_row_valid[r_phys] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_cur_col <= f_col;
                r_cur_row <= f_row;
                if (r_func == FN_CLEAR) begin
                    r_row_valid <= '0;
                    r_top       <= '0;
                end else if (f_scroll) begin
                    // The old top row becomes the blank bottom row.
                    r_row_valid[r_top] <= 1'b0;
                    r_top <= (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);
                end
            end
        end
    end

    assign o_m_axis_tdata = {7'd0, r_o_bad, r_o_scr, r_o_row, r_o_col, r_o_shown,
                             r_o_bg, r_o_fg, r_o_char};

endmodule

FILE: hw/rtl/text_console_cell_buffer.sv
// Text console cell buffer: character and attribute store with cursor, top level.
// Steps: accept, decode and address; then a cell write or read, or a fill of the whole row; then the
// registered result. No cell is touched for set cursor, clear, an ignored put, an off-screen read or a read
// of a blank row; a put into a row not written since the last clear or scroll fills that row.
// Throughput: one beat at a time; the next is accepted the cycle after its result is registered.
// Reset: synchronous, active low; attribute 0x0F, cursor 0,0 and every row reads as blank.
module text_console_cell_buffer #(
    parameter int COLS = tccb_pkg::DEF_COLS,
    parameter int ROWS = tccb_pkg::DEF_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // char_code[7:0], col[14:8], row[21:15], zero pad
    input  logic [tccb_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // func[1:0]
    input  logic [tccb_pkg::S_USER_W-1:0] i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // cell_char[7:0], fg_rgb[31:8], bg_rgb[55:32], cell_shown[56], cursor_col[63:57],
    // cursor_row[70:64], scrolled[71], bad_position[72], zero pad
    output logic [tccb_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [7:0]                    i_cfg_wdata
);
    import tccb_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tccb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    tccb_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("beat accepted while the previous one is still at work");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ({1'b0, o_m_axis_tdata[70:64]} < 8'(ROWS)))
        else $error("cursor row beyond the last screen row");

    a_bad_not_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[72] && o_m_axis_tdata[56]))
        else $error("out-of-range read reports a shown character");
`endif

endmodule
